### hdl/pba_pkg.sv
// ----------------------------------------------------------------------------
// Paged bump allocator package
// Shared widths, codes and request/response types for the allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    // Field widths of the request and response.
    localparam int SIZE_W   = 25;
    localparam int ALIGN_W  = 5;
    localparam int PIDX_W   = 6;
    localparam int OFF_W    = 24;

    // Rounding works on values up to 2^31, sums up to 2^32.
    localparam int RND_W    = 33;
    localparam int SUM_W    = 34;

    // Configuration port.
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Defaults.
    localparam int MAX_PAGES_DEF = 64;
    localparam logic [SIZE_W-1:0] PAGE_SIZE_RST = SIZE_W'(2097152);

    // Register indexes.
    localparam logic REG_PAGE_SIZE = 1'b0;

    // Request actions.
    typedef enum logic {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_FIT    = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef struct packed {
        logic               action;
        logic [SIZE_W-1:0]  alloc_size;
        logic [ALIGN_W-1:0] align_log2;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [PIDX_W-1:0]  page_index;
        logic [OFF_W-1:0]   chunk_offset;
        logic               page_created;
    } t_rsp;

endpackage

### hdl/pba_ifs.sv
// ----------------------------------------------------------------------------
// Paged bump allocator channels
// Valid/ready request and response channels of the allocator.
// ----------------------------------------------------------------------------
interface pba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [pba_pkg::SIZE_W-1:0]   alloc_size;
    logic [pba_pkg::ALIGN_W-1:0]  align_log2;

    modport source (output valid, action, alloc_size, align_log2, input ready);
    modport sink   (input valid, action, alloc_size, align_log2, output ready);
endinterface

interface pba_rsp_if;
    logic                        valid;
    logic                        ready;
    pba_pkg::t_status            status;
    logic [pba_pkg::PIDX_W-1:0]  page_index;
    logic [pba_pkg::OFF_W-1:0]   chunk_offset;
    logic                        page_created;

    modport source (output valid, status, page_index, chunk_offset, page_created,
                    input ready);
    modport sink   (input valid, status, page_index, chunk_offset, page_created,
                    output ready);
endinterface

### hdl/pba_cfg.sv
// ----------------------------------------------------------------------------
// Paged bump allocator configuration registers
// APB-style register file holding the page size.
// ----------------------------------------------------------------------------
module pba_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pba_pkg::APB_AW-1:0]   paddr,
    input  logic [pba_pkg::APB_DW-1:0]   pwdata,
    output logic [pba_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [pba_pkg::SIZE_W-1:0]   o_page_size
);

    logic                         w_reg_idx;
    logic                         w_wr;
    logic [pba_pkg::SIZE_W-1:0]   r_page_size;

    // Registers sit on 4-byte boundaries.
    assign w_reg_idx = paddr[2];
    assign w_wr      = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Page size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= pba_pkg::PAGE_SIZE_RST;
        end else if (w_wr && (w_reg_idx == pba_pkg::REG_PAGE_SIZE)) begin
            r_page_size <= pwdata[pba_pkg::SIZE_W-1:0];
        end
    end

    // Read back.
    always_comb begin
        prdata = '0;
        if (w_reg_idx == pba_pkg::REG_PAGE_SIZE) begin
            prdata = pba_pkg::APB_DW'(r_page_size);
        end
    end

    assign o_page_size = r_page_size;

endmodule

### hdl/pba_core.sv
// ----------------------------------------------------------------------------
// Paged bump allocator core
// Allocation state and the single-pass round, fit and page-advance logic.
// ----------------------------------------------------------------------------
module pba_core #(
    parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  pba_pkg::t_req               i_req,
    input  logic [pba_pkg::SIZE_W-1:0]  i_page_size,
    output pba_pkg::t_rsp               o_rsp
);

    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int IDX_W = (CNT_W > pba_pkg::PIDX_W) ? CNT_W : pba_pkg::PIDX_W;
    localparam int RND_W = pba_pkg::RND_W;
    localparam int SUM_W = pba_pkg::SUM_W;

    logic [CNT_W-1:0]           r_pool_cnt, n_pool_cnt;
    logic [CNT_W-1:0]           r_in_use,   n_in_use;
    logic [pba_pkg::SIZE_W-1:0] r_page_off, n_page_off;

    logic [RND_W-1:0]           w_mask;
    logic [RND_W-1:0]           w_asize;
    logic [RND_W-1:0]           w_aoff;
    logic [SUM_W-1:0]           w_end;
    logic                       w_too_large;
    logic                       w_need_page;
    logic                       w_asize_big;
    logic [IDX_W-1:0]           w_idx;

    // Round the current offset and the size up to the alignment.
    always_comb begin
        w_mask  = (RND_W'(1) << i_req.align_log2) - RND_W'(1);
        w_asize = (RND_W'(i_req.alloc_size) + w_mask) & ~w_mask;
        w_aoff  = (RND_W'(r_page_off) + w_mask) & ~w_mask;
        w_end   = SUM_W'(w_aoff) + SUM_W'(w_asize);
    end

    assign w_too_large = i_req.alloc_size > i_page_size;
    assign w_asize_big = w_asize > RND_W'(i_page_size);
    assign w_need_page = (r_in_use == '0) || (w_end > SUM_W'(i_page_size));

    // Page index of the current page after this request.
    assign w_idx = IDX_W'(n_in_use) - IDX_W'(1);

    // Decide the response and the next state.
    always_comb begin
        n_pool_cnt = r_pool_cnt;
        n_in_use   = r_in_use;
        n_page_off = r_page_off;
        o_rsp      = '0;
        o_rsp.status = pba_pkg::ST_OK;
        if (i_req.action == pba_pkg::ACT_RELEASE) begin
            n_in_use   = '0;
            n_page_off = '0;
        end else if (w_too_large) begin
            o_rsp.status = pba_pkg::ST_TOO_LARGE;
        end else if (!w_need_page) begin
            o_rsp.page_index   = w_idx[pba_pkg::PIDX_W-1:0];
            o_rsp.chunk_offset = w_aoff[pba_pkg::OFF_W-1:0];
            n_page_off         = w_end[pba_pkg::SIZE_W-1:0];
        end else if ((r_in_use >= r_pool_cnt) &&
                     (r_pool_cnt >= CNT_W'(MAX_PAGES))) begin
            o_rsp.status = pba_pkg::ST_EXHAUSTED;
        end else begin
            // Take the next pooled page, or grow the pool by one.
            n_in_use = r_in_use + CNT_W'(1);
            if (r_in_use >= r_pool_cnt) begin
                n_pool_cnt         = r_pool_cnt + CNT_W'(1);
                o_rsp.page_created = 1'b1;
            end
            if (w_asize_big) begin
                o_rsp.status = pba_pkg::ST_NO_FIT;
                n_page_off   = '0;
            end else begin
                o_rsp.page_index = w_idx[pba_pkg::PIDX_W-1:0];
                n_page_off       = w_asize[pba_pkg::SIZE_W-1:0];
            end
        end
    end

    // Allocation state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_cnt <= '0;
            r_in_use   <= '0;
            r_page_off <= '0;
        end else if (i_fire) begin
            r_pool_cnt <= n_pool_cnt;
            r_in_use   <= n_in_use;
            r_page_off <= n_page_off;
        end
    end

endmodule

### hdl/paged_bump_allocator.sv
// ----------------------------------------------------------------------------
// Paged bump allocator
// Serves aligned chunks from a pool of fixed-size pages.
// ----------------------------------------------------------------------------
// Usage: requests arrive on i_req (valid/ready). An allocate request returns
// the page index and aligned offset of a chunk; a release request frees all
// pages while the pool keeps them for reuse in order. Every request yields
// exactly one response on o_rsp, in order.
// Flow: a request accepted into the input register is processed by one pass
// of round-up, fit and page-advance logic, and its response is loaded into
// the response register once the output is free, then held on o_rsp until taken.
// Throughput: one request per cycle while o_rsp is taken; the single-pass
// allocation logic and its state registers update once per request.
// Reset: pool, pages in use and bump offset clear; page size returns to
// 2 MiB. When the receiver stalls, the response register holds and the
// input register fills; i_req.ready then drops until o_rsp is taken.
// The page size is set through the APB port at byte address 0.
// ----------------------------------------------------------------------------
module paged_bump_allocator #(
    parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pba_req_if.sink                     i_req,
    pba_rsp_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pba_pkg::APB_AW-1:0]  paddr,
    input  logic [pba_pkg::APB_DW-1:0]  pwdata,
    output logic [pba_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    logic                        r_in_vld;
    pba_pkg::t_req               r_in;
    logic                        r_out_vld;
    pba_pkg::t_rsp               r_out;
    logic                        w_adv;
    logic                        w_take;
    logic [pba_pkg::SIZE_W-1:0]  w_page_size;
    pba_pkg::t_rsp               w_rsp;

    pba_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_page_size (w_page_size)
    );

    pba_core #(
        .MAX_PAGES (MAX_PAGES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_adv),
        .i_req       (r_in),
        .i_page_size (w_page_size),
        .o_rsp       (w_rsp)
    );

    // Pipeline handshake: the input stage moves on when the output is free.
    assign w_adv       = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || w_adv;
    assign w_take      = i_req.valid && i_req.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.action     <= i_req.action;
            r_in.alloc_size <= i_req.alloc_size;
            r_in.align_log2 <= i_req.align_log2;
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_rsp;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.page_index   = r_out.page_index;
    assign o_rsp.chunk_offset = r_out.chunk_offset;
    assign o_rsp.page_created = r_out.page_created;

endmodule
